// ===== design/slfw_pkg.sv =====
`timescale 1ns / 1ps

package slfw_pkg;

    localparam int FRAME_W = 17;
    localparam int LEN_W   = 5;

    localparam logic [3:0] PREFIX_CMD   = 4'h8;
    localparam logic [2:0] PREFIX_WRITE = 3'h5;
    localparam logic [7:0] DOT_BIT      = 8'h80;
    localparam logic [7:0] H_PATTERN    = 8'h76;

    localparam logic [5:0] ADDR_FIRST = 6'd0;
    localparam logic [5:0] ADDR_THIRD = 6'd2;
    localparam logic [5:0] ADDR_LAST  = 6'd4;

    localparam logic [LEN_W-1:0] LEN_NONE   = 5'd0;
    localparam logic [LEN_W-1:0] LEN_CMD    = 5'd12;
    localparam logic [LEN_W-1:0] LEN_NIBBLE = 5'd13;
    localparam logic [LEN_W-1:0] LEN_BYTE   = 5'd17;

    typedef enum logic [2:0] {
        OP_CMD    = 3'd0,
        OP_NIBBLE = 3'd1,
        OP_BYTE   = 3'd2,
        OP_FIRST  = 3'd3,
        OP_THIRD  = 3'd4,
        OP_LAST   = 3'd5,
        OP_H      = 3'd6
    } t_opcode;

    // frame left-aligned, first bit in the top position
    typedef struct packed {
        logic [FRAME_W-1:0] word;
        logic [LEN_W-1:0]   len;
    } t_frame;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h5f;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h6b;
            4'd3:    pat = 8'h2f;
            4'd4:    pat = 8'h36;
            4'd5:    pat = 8'h3d;
            4'd6:    pat = 8'h7d;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7f;
            4'd9:    pat = 8'h3f;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/slfw_if.sv =====
`timescale 1ns / 1ps

interface slfw_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [5:0] address;
    logic [7:0] value;

    modport source (output valid, output opcode, output address, output value, input ready);
    modport sink   (input valid, input opcode, input address, input value, output ready);
endinterface

interface slfw_bit_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic frame_end;

    modport source (output valid, output serial_bit, output frame_end, input ready);
    modport sink   (input valid, input serial_bit, input frame_end, output ready);
endinterface

// ===== design/segment_lcd_serial_frame_writer_core.sv =====
`timescale 1ns / 1ps

// serial frame writer for a three-wire lcd segment controller
//
// i_req: one request per transfer (opcode, address, value). each request
// becomes one frame: command 12 bits, nibble write 13 bits, byte write and
// display operations 17 bits. digits out of range and the unused opcode are
// taken and give no bits.
// o_bit: one frame bit per transfer, most significant first, frame_end high
// on the last bit.
//
// the first bit is shown the cycle after the request transfer.
// one bit per cycle from the output shift register while the receiver is
// ready; the next request is taken in the cycle its predecessor's last bit
// leaves.
//
// reset clears the bit counter, so no bit is shown after reset.
// when the receiver stalls the current bit holds and no request is taken.
module segment_lcd_serial_frame_writer_core
    import slfw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    slfw_req_if.sink    i_req,
    slfw_bit_if.source  o_bit
);

    t_frame w_frame;
    logic   w_idle_next;

    assign i_req.ready = w_idle_next;

    slfw_encode u_encode (
        .i_opcode  (i_req.opcode),
        .i_address (i_req.address),
        .i_value   (i_req.value),
        .o_frame   (w_frame)
    );

    slfw_shift u_shift (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (i_req.valid && w_idle_next),
        .i_frame      (w_frame),
        .i_out_ready  (o_bit.ready),
        .o_out_valid  (o_bit.valid),
        .o_serial_bit (o_bit.serial_bit),
        .o_frame_end  (o_bit.frame_end),
        .o_idle_next  (w_idle_next)
    );

endmodule

// ===== design/slfw_encode.sv =====
`timescale 1ns / 1ps

module slfw_encode
    import slfw_pkg::*;
(
    input  logic [2:0] i_opcode,
    input  logic [5:0] i_address,
    input  logic [7:0] i_value,
    output t_frame     o_frame
);

    logic       w_small;
    logic       w_teen;
    logic [3:0] w_digit;

    assign w_small = (i_value < 8'd10);
    assign w_teen  = (i_value >= 8'd10) && (i_value < 8'd20);
    // low digit of 0..19
    assign w_digit = w_teen ? 4'(i_value[4:0] - 5'd10) : i_value[3:0];

    always_comb begin
        o_frame.word = '0;
        o_frame.len  = LEN_NONE;
        unique case (t_opcode'(i_opcode))
            OP_CMD: begin
                o_frame.word = {PREFIX_CMD, i_value, 5'b0};
                o_frame.len  = LEN_CMD;
            end
            OP_NIBBLE: begin
                o_frame.word = {PREFIX_WRITE, i_address, i_value[3:0], 4'b0};
                o_frame.len  = LEN_NIBBLE;
            end
            OP_BYTE: begin
                o_frame.word = {PREFIX_WRITE, i_address, i_value};
                o_frame.len  = LEN_BYTE;
            end
            OP_FIRST: begin
                if (w_small || w_teen) begin
                    o_frame.word = {PREFIX_WRITE, ADDR_FIRST,
                                    seg_pattern(w_digit) | (w_teen ? DOT_BIT : 8'h00)};
                    o_frame.len  = LEN_BYTE;
                end
            end
            OP_THIRD: begin
                if (w_small) begin
                    o_frame.word = {PREFIX_WRITE, ADDR_THIRD, seg_pattern(i_value[3:0])};
                    o_frame.len  = LEN_BYTE;
                end
            end
            OP_LAST: begin
                if (w_small) begin
                    o_frame.word = {PREFIX_WRITE, ADDR_LAST,
                                    seg_pattern(i_value[3:0]) | DOT_BIT};
                    o_frame.len  = LEN_BYTE;
                end
            end
            OP_H: begin
                o_frame.word = {PREFIX_WRITE, ADDR_LAST, H_PATTERN};
                o_frame.len  = LEN_BYTE;
            end
            default: begin
                o_frame.word = '0;
                o_frame.len  = LEN_NONE;
            end
        endcase
    end

endmodule

// ===== design/slfw_shift.sv =====
`timescale 1ns / 1ps

module slfw_shift
    import slfw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_frame i_frame,
    input  logic   i_out_ready,
    output logic   o_out_valid,
    output logic   o_serial_bit,
    output logic   o_frame_end,
    output logic   o_idle_next
);

    logic [FRAME_W-1:0] r_word, n_word;
    logic [LEN_W-1:0]   r_left, n_left;
    logic               w_xfer;

    assign o_out_valid  = (r_left != LEN_NONE);
    assign o_serial_bit = r_word[FRAME_W-1];
    assign o_frame_end  = (r_left == LEN_W'(1));
    assign w_xfer       = o_out_valid && i_out_ready;
    // free now, or last bit leaving this cycle
    assign o_idle_next  = !o_out_valid || (o_frame_end && i_out_ready);

    always_comb begin
        priority if (i_load) begin
            n_word = i_frame.word;
            n_left = i_frame.len;
        end else if (w_xfer) begin
            n_word = {r_word[FRAME_W-2:0], 1'b0};
            n_left = r_left - LEN_W'(1);
        end else begin
            n_word = r_word;
            n_left = r_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= LEN_NONE;
        end else begin
            r_left <= n_left;
        end
        r_word <= n_word;
    end

endmodule

// ===== design/slfw_checker.sv =====
`timescale 1ns / 1ps

module slfw_checker
    import slfw_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [2:0] i_in_opcode,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_bit,
    input logic       i_out_end
);

    // a stalled bit holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_bit) && $stable(i_out_end))
        else $error("stalled bit changed");

    // no request taken in the middle of a frame
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || (i_out_end && i_out_ready))
        else $error("request taken during a frame");

    // a frame does not stop before its last bit
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_end |=> i_out_valid)
        else $error("frame broken off");

    // a byte write starts with the write prefix
    a_byte_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_opcode == OP_BYTE)
        |=> i_out_valid && i_out_bit && !i_out_end)
        else $error("byte write frame missing");

endmodule

bind segment_lcd_serial_frame_writer_core slfw_checker u_slfw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_opcode (i_req.opcode),
    .i_out_valid (o_bit.valid),
    .i_out_ready (o_bit.ready),
    .i_out_bit   (o_bit.serial_bit),
    .i_out_end   (o_bit.frame_end)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import slfw_pkg::*;

    localparam logic [2:0] OP_UNUSED    = 3'd7;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_ITEMS = 105;
    localparam int         MAX_REPORTS  = 10;

    // seven-segment patterns, digit 0 in the lowest byte
    localparam logic [9:0][7:0] DIGIT_SEGMENTS = {
        8'h3f, 8'h7f, 8'h07, 8'h7d, 8'h3d, 8'h36, 8'h2f, 8'h6b, 8'h06, 8'h5f
    };

    typedef struct {
        logic       serial_bit;
        logic       frame_end;
    } t_frame_bit;

    typedef struct {
        logic [2:0]       opcode;
        logic [5:0]       address;
        logic [7:0]       value;
        bit               typed;
        logic [16:0]      word;
        logic [LEN_W-1:0] len;
    } t_req_row;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic clk;
    logic rst_n;

    slfw_req_if req_if ();
    slfw_bit_if bit_if ();

    segment_lcd_serial_frame_writer_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_bit   (bit_if)
    );

    t_frame_bit  pending_bits[$];
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned burst_left;

    // row typed = 1: word/len written out by hand, else taken from encode_frame
    t_req_row directed_rows [25] = '{
        '{OP_CMD,    6'd0,  8'h00, 1'b1, 17'h00800, LEN_CMD},
        '{OP_CMD,    6'd63, 8'hff, 1'b1, 17'h008ff, LEN_CMD},
        '{OP_CMD,    6'd37, 8'h9c, 1'b0, 17'h0,     LEN_NONE},
        '{OP_NIBBLE, 6'd0,  8'h00, 1'b1, 17'h01400, LEN_NIBBLE},
        '{OP_NIBBLE, 6'd63, 8'hff, 1'b1, 17'h017ff, LEN_NIBBLE},
        '{OP_NIBBLE, 6'd21, 8'hf0, 1'b0, 17'h0,     LEN_NONE},
        '{OP_BYTE,   6'd0,  8'h00, 1'b1, 17'h14000, LEN_BYTE},
        '{OP_BYTE,   6'd63, 8'hff, 1'b1, 17'h17fff, LEN_BYTE},
        '{OP_BYTE,   6'd42, 8'h5a, 1'b0, 17'h0,     LEN_NONE},
        '{OP_FIRST,  6'd0,  8'd0,  1'b0, 17'h0,     LEN_NONE},
        '{OP_FIRST,  6'd11, 8'd9,  1'b0, 17'h0,     LEN_NONE},
        '{OP_FIRST,  6'd0,  8'd10, 1'b0, 17'h0,     LEN_NONE},
        '{OP_FIRST,  6'd63, 8'd19, 1'b0, 17'h0,     LEN_NONE},
        '{OP_FIRST,  6'd0,  8'd20, 1'b1, 17'h0,     LEN_NONE},
        '{OP_FIRST,  6'd0,  8'hff, 1'b1, 17'h0,     LEN_NONE},
        '{OP_THIRD,  6'd0,  8'd0,  1'b0, 17'h0,     LEN_NONE},
        '{OP_THIRD,  6'd63, 8'd9,  1'b0, 17'h0,     LEN_NONE},
        '{OP_THIRD,  6'd0,  8'd10, 1'b1, 17'h0,     LEN_NONE},
        '{OP_LAST,   6'd0,  8'd0,  1'b0, 17'h0,     LEN_NONE},
        '{OP_LAST,   6'd5,  8'd9,  1'b0, 17'h0,     LEN_NONE},
        '{OP_LAST,   6'd0,  8'd10, 1'b1, 17'h0,     LEN_NONE},
        '{OP_LAST,   6'd0,  8'hff, 1'b1, 17'h0,     LEN_NONE},
        '{OP_H,      6'd17, 8'hc8, 1'b1, 17'h14476, LEN_BYTE},
        '{OP_H,      6'd0,  8'h00, 1'b1, 17'h14476, LEN_BYTE},
        '{OP_UNUSED, 6'd63, 8'hff, 1'b1, 17'h0,     LEN_NONE}
    };

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void encode_frame(input logic [2:0] op, input logic [5:0] addr,
                                         input logic [7:0] val,
                                         output logic [16:0] word,
                                         output logic [LEN_W-1:0] len);
        logic [7:0] seg;
        word = '0;
        len  = LEN_NONE;
        case (op)
            OP_CMD: begin
                word = {5'd0, PREFIX_CMD, val};
                len  = LEN_CMD;
            end
            OP_NIBBLE: begin
                word = {4'd0, PREFIX_WRITE, addr, val[3:0]};
                len  = LEN_NIBBLE;
            end
            OP_BYTE: begin
                word = {PREFIX_WRITE, addr, val};
                len  = LEN_BYTE;
            end
            OP_FIRST: begin
                if (val <= 8'd19) begin
                    seg = DIGIT_SEGMENTS[val % 10];
                    if (val >= 8'd10)
                        seg = seg | DOT_BIT;
                    word = {PREFIX_WRITE, ADDR_FIRST, seg};
                    len  = LEN_BYTE;
                end
            end
            OP_THIRD: begin
                if (val <= 8'd9) begin
                    word = {PREFIX_WRITE, ADDR_THIRD, DIGIT_SEGMENTS[val]};
                    len  = LEN_BYTE;
                end
            end
            OP_LAST: begin
                if (val <= 8'd9) begin
                    word = {PREFIX_WRITE, ADDR_LAST, DIGIT_SEGMENTS[val] | DOT_BIT};
                    len  = LEN_BYTE;
                end
            end
            OP_H: begin
                word = {PREFIX_WRITE, ADDR_LAST, H_PATTERN};
                len  = LEN_BYTE;
            end
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // drive one request, hold it until the transfer, then queue its frame bits
    task automatic send_req(input logic [2:0] op, input logic [5:0] addr,
                            input logic [7:0] val, input logic [16:0] word,
                            input logic [LEN_W-1:0] len);
        req_if.valid   <= 1'b1;
        req_if.opcode  <= op;
        req_if.address <= addr;
        req_if.value   <= val;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        for (int i = int'(len) - 1; i >= 0; i--)
            pending_bits.push_back('{word[i], i == 0});
    endtask

    // bursts of back-to-back requests separated by random gaps
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 9);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic pick_random_req(output logic [2:0] op, output logic [5:0] addr,
                                   output logic [7:0] val);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        addr = 6'($urandom_range(0, 63));
        val  = 8'($urandom_range(0, 255));
        if (pick < 12) begin
            op = OP_CMD;
        end else if (pick < 24) begin
            op = OP_NIBBLE;
        end else if (pick < 40) begin
            op = OP_BYTE;
        end else if (pick < 55) begin
            op  = OP_FIRST;
            val = 8'($urandom_range(0, 19));
        end else if (pick < 67) begin
            op  = OP_THIRD;
            val = 8'($urandom_range(0, 9));
        end else if (pick < 79) begin
            op  = OP_LAST;
            val = 8'($urandom_range(0, 9));
        end else if (pick < 86) begin
            op = OP_H;
        end else if (pick < 94) begin
            op  = 3'($urandom_range(OP_FIRST, OP_LAST));
            val = (op == OP_FIRST) ? 8'($urandom_range(20, 255))
                                   : 8'($urandom_range(10, 255));
        end else begin
            op = OP_UNUSED;
        end
    endtask

    // receiver: check each bit transfer, stall in changing patterns
    initial begin
        t_frame_bit  want;
        t_rx_mode    rx_mode;
        int unsigned rx_phase;
        rx_mode  = RX_ALWAYS;
        rx_phase = 0;
        bit_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && bit_if.valid && bit_if.ready) begin
                if (pending_bits.size() == 0) begin
                    note_failure($sformatf("unexpected transfer: bit %b end %b",
                                           bit_if.serial_bit, bit_if.frame_end));
                end else begin
                    want = pending_bits.pop_front();
                    if (bit_if.serial_bit !== want.serial_bit)
                        note_failure($sformatf("serial_bit: expected %b, got %b",
                                               want.serial_bit, bit_if.serial_bit));
                    if (bit_if.frame_end !== want.frame_end)
                        note_failure($sformatf("frame_end: expected %b, got %b",
                                               want.frame_end, bit_if.frame_end));
                end
            end
            rx_phase++;
            if (rx_phase % 40 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_ALWAYS: bit_if.ready <= 1'b1;
                RX_RANDOM: bit_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: bit_if.ready <= (rx_phase % 5 == 0);
                default:   bit_if.ready <= rx_phase[3];
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("segment_lcd_serial_frame_writer_core: mismatch");
            $finish;
        end
    end

    initial begin
        logic [2:0]       op;
        logic [5:0]       addr;
        logic [7:0]       val;
        logic [16:0]      word;
        logic [LEN_W-1:0] len;
        fail_count  = 0;
        cycle_count = 0;
        burst_left  = 0;
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.opcode  <= '0;
        req_if.address <= '0;
        req_if.value   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].typed) begin
                word = directed_rows[i].word;
                len  = directed_rows[i].len;
            end else begin
                encode_frame(directed_rows[i].opcode, directed_rows[i].address,
                             directed_rows[i].value, word, len);
            end
            send_req(directed_rows[i].opcode, directed_rows[i].address,
                     directed_rows[i].value, word, len);
            pace_sender();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick_random_req(op, addr, val);
            encode_frame(op, addr, val, word, len);
            send_req(op, addr, val, word, len);
            if (n == RANDOM_ITEMS / 2) begin
                // let the output side drain completely before carrying on
                req_if.valid <= 1'b0;
                while (pending_bits.size() != 0)
                    @(posedge clk);
            end else begin
                pace_sender();
            end
        end

        req_if.valid <= 1'b0;
        while (pending_bits.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_bits.size() == 0)
            $display("segment_lcd_serial_frame_writer_core: match");
        else
            $display("segment_lcd_serial_frame_writer_core: mismatch");
        $finish;
    end

endmodule
